>>> rtl/core/nearest_palette_color_search_macros.svh
// Assertion macros for the nearest palette color search block
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// expr must hold at every clock edge outside reset
`define NPCS_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// cons must hold at the same edge as ante
`define NPCS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define NPCS_ASSERT_ALWAYS(label, clk, rst, expr)
`define NPCS_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/core/npcs_pkg.sv
// Shared types and constants for the nearest palette color search block
package npcs_pkg;

   localparam int NPCS_PALETTE_DEPTH = 256;
   localparam int NPCS_MAX_SEARCH    = 256;
   localparam int NPCS_QUEUE_DEPTH   = 4;

   localparam int COLOR_W = 8;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 9;
   localparam int SQ_W    = 16;
   localparam int DIST_W  = 18;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register index of entries_in_use
   localparam logic REG_ENTRIES_IN_USE = 1'b0;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic               is_query;
      logic [INDEX_W-1:0] slot;
      color_type          color;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

>>> rtl/core/npcs_front.sv
// Front end: accepts requests, drops out-of-range loads, queues commands in order
module npcs_front
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = NPCS_PALETTE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,   // entry_index, red, green, blue
   input  logic                req_tuser,   // op
   output queue_out_type       q_out,
   input  logic                q_pop
);

   localparam int QAW = $clog2(NPCS_QUEUE_DEPTH);
   localparam logic [12:0] DEPTH_LIMIT = 13'(PALETTE_DEPTH);

   cmd_type            queue_ff [NPCS_QUEUE_DEPTH];
   logic [QAW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QAW:0]       count_ff, count_in;

   cmd_type            cmd;
   logic               keep;
   logic               push;
   logic               pop;

   always_comb begin
      cmd.is_query    = (req_tuser == OP_QUERY);
      cmd.slot        = req_tdata[7:0];
      cmd.color.red   = req_tdata[15:8];
      cmd.color.green = req_tdata[23:16];
      cmd.color.blue  = req_tdata[31:24];
      // a load past the end of the palette has no effect at all
      keep = cmd.is_query || ({5'd0, cmd.slot} < DEPTH_LIMIT);
   end

   assign req_tready = (count_ff != (QAW+1)'(NPCS_QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign pop        = q_pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign q_out.valid = (count_ff != '0);
   assign q_out.cmd   = queue_ff[rd_ptr_ff];

endmodule

>>> rtl/core/npcs_back.sv
// Back end: palette memory, sequential distance scan and result register
module npcs_back
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = NPCS_PALETTE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_out_type       q_in,
   output logic                q_pop,
   input  logic [COUNT_W-1:0]  entries_in_use,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata    // nearest_index, nearest_distance
);

   localparam int AW = $clog2(PALETTE_DEPTH);
   localparam int CAP = (PALETTE_DEPTH < NPCS_MAX_SEARCH) ? PALETTE_DEPTH : NPCS_MAX_SEARCH;
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH,
      ST_HOLD
   } state_type;

   logic [23:0]         palette_mem [PALETTE_DEPTH];
   logic [23:0]         rd_data_ff;

   state_type           state_ff, state_in;
   color_type           color_ff, color_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [INDEX_W-1:0]  last_idx_ff, last_idx_in;
   logic [DIST_W-1:0]   best_dist_ff, best_dist_in;
   logic [INDEX_W-1:0]  best_idx_ff, best_idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;

   logic                p1_valid_ff, p1_valid_in;
   logic                p1_last_ff, p1_last_in;
   logic [INDEX_W-1:0]  p1_idx_ff;
   logic                p2_valid_ff;
   logic                p2_last_ff;
   logic [INDEX_W-1:0]  p2_idx_ff;
   logic [SQ_W-1:0]     sq_r_ff, sq_g_ff, sq_b_ff;

   logic [COUNT_W-1:0]  search_n;
   logic                mem_we;
   logic [AW-1:0]       rd_addr;
   logic [COLOR_W-1:0]  d_r, d_g, d_b;
   logic [DIST_W-1:0]   dist_sum;
   logic                out_free;

   // zero entries searches entry 0 alone; count saturates at the index range
   always_comb begin
      if (entries_in_use == '0) begin
         search_n = COUNT_W'(1);
      end else if (entries_in_use > CAP_COUNT) begin
         search_n = CAP_COUNT;
      end else begin
         search_n = entries_in_use;
      end
   end

   assign q_pop    = (state_ff == ST_IDLE) && q_in.valid;
   assign mem_we   = q_pop && !q_in.cmd.is_query;
   assign rd_addr  = AW'(idx_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[AW'(q_in.cmd.slot)] <= q_in.cmd.color;
      end
      rd_data_ff <= palette_mem[rd_addr];
   end

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   always_comb begin
      d_r = abs_diff(color_ff.red,   rd_data_ff[23:16]);
      d_g = abs_diff(color_ff.green, rd_data_ff[15:8]);
      d_b = abs_diff(color_ff.blue,  rd_data_ff[7:0]);
   end

   // squares registered, then summed and compared one stage later
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p1_valid_ff;
      end
      p1_last_ff <= p1_last_in;
      p1_idx_ff  <= idx_ff;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
      sq_r_ff    <= SQ_W'(d_r) * SQ_W'(d_r);
      sq_g_ff    <= SQ_W'(d_g) * SQ_W'(d_g);
      sq_b_ff    <= SQ_W'(d_b) * SQ_W'(d_b);
   end

   assign dist_sum = DIST_W'(sq_r_ff) + DIST_W'(sq_g_ff) + DIST_W'(sq_b_ff);

   always_comb begin
      state_in     = state_ff;
      color_in     = color_ff;
      idx_in       = idx_ff;
      last_idx_in  = last_idx_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_dist_in  = rsp_dist_ff;
      p1_valid_in  = 1'b0;
      p1_last_in   = 1'b0;

      // strict less-than keeps the lowest index on a tie
      if (p2_valid_ff && (dist_sum < best_dist_ff)) begin
         best_dist_in = dist_sum;
         best_idx_in  = p2_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_pop && q_in.cmd.is_query) begin
               color_in     = q_in.cmd.color;
               idx_in       = '0;
               last_idx_in  = INDEX_W'(search_n - 1'b1);
               best_dist_in = '1;
               best_idx_in  = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            p1_valid_in = 1'b1;
            p1_last_in  = (idx_ff == last_idx_ff);
            idx_in      = idx_ff + 1'b1;
            if (idx_ff == last_idx_ff) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (p2_valid_ff && p2_last_ff) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = best_idx_ff;
               rsp_dist_in  = best_dist_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      color_ff     <= color_in;
      idx_ff       <= idx_in;
      last_idx_ff  <= last_idx_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dist_ff, rsp_idx_ff};

endmodule

>>> rtl/core/nearest_palette_color_search.sv
// A load is written to palette memory as it leaves the queue; a query's result is registered
// after its memory read, square and best-match stages. The scan makes one memory read per cycle
// over n = searched entries (1..256); the back end finishes one query before it takes the next.
// A 4-deep command queue keeps accepting requests while the scan runs or a result waits.
// Reset (synchronous) empties the queue and result register and sets entries_in_use to 1;
// palette contents are not cleared and are undefined until loaded.
`include "nearest_palette_color_search_macros.svh"

module nearest_palette_color_search
   import npcs_pkg::*;
#(
   parameter int PALETTE_DEPTH = NPCS_PALETTE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // entry_index, red, green, blue
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // nearest_index, nearest_distance
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [COUNT_W-1:0]  entries_ff, entries_in;
   logic                csr_write;
   queue_out_type       q_out;
   logic                q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      entries_in = entries_ff;
      if (csr_write && (csr_paddr[2] == REG_ENTRIES_IN_USE)) begin
         entries_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= COUNT_W'(1);
      end else begin
         entries_ff <= entries_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_ENTRIES_IN_USE) ?
                       {{(32-COUNT_W){1'b0}}, entries_ff} : 32'd0;

   npcs_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_out      (q_out),
      .q_pop      (q_pop)
   );

   npcs_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_in           (q_out),
      .q_pop          (q_pop),
      .entries_in_use (entries_ff),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata)
   );

   `NPCS_ASSERT_IMPLIES(a_dist_range, clock, reset, rsp_tvalid, rsp_tdata[25:8] <= 18'd195075)
   `NPCS_ASSERT_IMPLIES(a_index_in_use, clock, reset, rsp_tvalid,
                        (entries_ff == '0) || ({1'b0, rsp_tdata[7:0]} < entries_ff))
   `NPCS_ASSERT_IMPLIES(a_ready_after_reset, clock, reset, $fell(reset), req_tready)

endmodule

>>> dv/tb_nearest_palette_color_search.sv
// Self-checking testbench for the nearest palette color search block
module tb_nearest_palette_color_search;
   timeunit 1ns;
   timeprecision 1ps;
   import npcs_pkg::*;

   localparam logic [2:0] ENTRIES_ADDR  = {REG_ENTRIES_IN_USE, 2'b00};
   localparam logic [2:0] UNMAPPED_ADDR = 3'd4;   // word after the last register
   localparam int SETTLE_CYCLES   = 20;
   localparam int TAIL_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int MAX_REPORTS     = 10;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
   } match_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // entry_index, red, green, blue
   logic        req_tuser = 1'b0; // op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // nearest_index, nearest_distance
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // predictor state
   color_type          palette_copy [NPCS_PALETTE_DEPTH];
   bit                 loaded [NPCS_PALETTE_DEPTH];
   logic [COUNT_W-1:0] span_setting = 9'd1;
   match_type          nearest_expected [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int load_count     = 0;
   int query_count    = 0;
   int csr_write_count = 0;
   int idle_cycles    = 0;

   nearest_palette_color_search uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------- predictor

   function automatic int search_span();
      int n;
      n = int'(span_setting);
      if (n == 0) n = 1;
      if (n > NPCS_MAX_SEARCH) n = NPCS_MAX_SEARCH;
      if (n > NPCS_PALETTE_DEPTH) n = NPCS_PALETTE_DEPTH;
      return n;
   endfunction

   function automatic match_type find_nearest(input color_type c);
      match_type best;
      int best_d, d, dr, dg, db;
      best.index = '0;
      best_d = 32'h7fff_ffff;
      for (int i = 0; i < search_span(); i++) begin
         dr = int'(c.red)   - int'(palette_copy[i].red);
         dg = int'(c.green) - int'(palette_copy[i].green);
         db = int'(c.blue)  - int'(palette_copy[i].blue);
         d = dr * dr + dg * dg + db * db;
         if (d < best_d) begin
            best_d = d;
            best.index = i[INDEX_W-1:0];
         end
      end
      best.distance = best_d[DIST_W-1:0];
      return best;
   endfunction

   // first slot inside the search span never loaded, -1 if none
   function automatic int first_gap();
      for (int i = 0; i < search_span(); i++)
         if (!loaded[i]) return i;
      return -1;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [COLOR_W-1:0] pick_level();
      case ($urandom_range(4))
         0: return 8'd0;
         1: return 8'd64;
         2: return 8'd128;
         3: return 8'd192;
         default: return 8'd255;
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] nudge(input logic [COLOR_W-1:0] v);
      int t;
      t = int'(v) + int'($urandom_range(6)) - 3;
      if (t < 0) t = 0;
      if (t > 255) t = 255;
      return t[COLOR_W-1:0];
   endfunction

   function automatic color_type pick_color();
      color_type c;
      int j;
      j = $urandom_range(NPCS_PALETTE_DEPTH - 1);
      case ($urandom_range(9))
         0, 1, 2: c = color_type'(24'($urandom));
         3, 4: begin
            c.red   = $urandom_range(1) ? 8'd255 : 8'd0;
            c.green = $urandom_range(1) ? 8'd255 : 8'd0;
            c.blue  = $urandom_range(1) ? 8'd255 : 8'd0;
         end
         5, 6: begin
            // coarse levels give plenty of duplicate entries and ties
            c.red   = pick_level();
            c.green = pick_level();
            c.blue  = pick_level();
         end
         default: begin
            if (loaded[j]) begin
               c.red   = nudge(palette_copy[j].red);
               c.green = nudge(palette_copy[j].green);
               c.blue  = nudge(palette_copy[j].blue);
            end else begin
               c = color_type'(24'($urandom));
            end
         end
      endcase
      return c;
   endfunction

   // called at a falling edge, returns at the falling edge after the accept
   task automatic send_request(input logic op, input logic [INDEX_W-1:0] slot,
                               input color_type c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {c.blue, c.green, c.red, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         palette_copy[slot] = c;
         loaded[slot] = 1'b1;
         load_count++;
      end else begin
         nearest_expected.push_back(find_nearest(c));
         query_count++;
      end
      @(negedge clock);
   endtask

   task automatic send_load(input int slot, input int r, input int g, input int b);
      send_request(OP_LOAD, slot[INDEX_W-1:0], {r[7:0], g[7:0], b[7:0]});
   endtask

   task automatic send_query(input int r, input int g, input int b);
      send_request(OP_QUERY, INDEX_W'($urandom_range(255)), {r[7:0], g[7:0], b[7:0]});
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (nearest_expected.size() != 0) @(negedge clock);
      // queued loads produce no result; give them time to retire
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("ERROR %s: expected %h, got %h at %0t", what, want, got, $realtime);
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ENTRIES_ADDR) span_setting = data[COUNT_W-1:0];
      csr_write_count++;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_span_readback();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ENTRIES_ADDR;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {23'd0, span_setting})
         note_mismatch("entries_in_use readback", {23'd0, span_setting}, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits are random, only the low nine bits hold the count
   task automatic set_span(input int value);
      drain_pipeline();
      write_csr(ENTRIES_ADDR, ($urandom & ~32'h1ff) | 32'(value[COUNT_W-1:0]));
      check_span_readback();
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_results
      match_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (nearest_expected.size() == 0) begin
            note_mismatch("result with no query pending", 32'h0, rsp_tdata);
         end else begin
            want = nearest_expected.pop_front();
            if (rsp_tdata[INDEX_W-1:0] !== want.index)
               note_mismatch("nearest_index", 32'(want.index),
                             32'(rsp_tdata[INDEX_W-1:0]));
            if (rsp_tdata[INDEX_W +: DIST_W] !== want.distance)
               note_mismatch("nearest_distance", 32'(want.distance),
                             32'(rsp_tdata[INDEX_W +: DIST_W]));
            if (rsp_tdata[31:INDEX_W+DIST_W] !== '0)
               note_mismatch("result padding", 32'h0, rsp_tdata);
         end
      end
   end

   initial begin : watchdog
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // count is 1 after reset: only entry 0 is searched
   task automatic test_reset_default();
      check_span_readback();
      send_load(0, 0, 0, 0);
      send_query(255, 255, 255);   // largest possible distance
      send_query(0, 0, 0);
   endtask

   task automatic test_ties_and_extremes();
      set_span(4);
      send_load(0, 40, 80, 120);
      send_load(1, 40, 80, 120);   // duplicate of entry 0
      send_load(2, 0, 0, 0);
      send_load(3, 2, 0, 0);
      send_load(255, 255, 255, 255);   // top slot, outside the span
      send_query(40, 80, 120);     // exact tie, lower index wins
      send_query(1, 0, 0);         // entries 2 and 3 equidistant
      send_query(255, 255, 255);
      send_query(0, 255, 0);
      send_query(255, 0, 255);
   endtask

   task automatic test_palette_fill();
      int order [NPCS_PALETTE_DEPTH];
      int k, tmp;
      drain_pipeline();
      for (int i = 0; i < NPCS_PALETTE_DEPTH; i++) order[i] = i;
      for (int i = NPCS_PALETTE_DEPTH - 1; i > 0; i--) begin
         k = $urandom_range(i);
         tmp = order[i];
         order[i] = order[k];
         order[k] = tmp;
      end
      send_idle_pct = 20;
      for (int i = 0; i < NPCS_PALETTE_DEPTH; i++)
         send_request(OP_LOAD, order[i][INDEX_W-1:0], pick_color());
      send_idle_pct = 0;
   endtask

   task automatic test_span_limits();
      set_span(0);                 // zero counts as one entry
      send_query(255, 255, 255);
      set_span(256);
      send_query(0, 0, 0);
      send_query(255, 255, 255);
      send_query($urandom_range(255), $urandom_range(255), $urandom_range(255));
      set_span(300);               // saturates at 256
      send_query(128, 128, 128);
      set_span(511);
      send_query(255, 0, 0);
      drain_pipeline();
      write_csr(UNMAPPED_ADDR, 32'd3);   // no register there, count stays 511
      check_span_readback();
      send_query(0, 0, 255);
   endtask

   task automatic run_random_phase(input int span_value, input int items, input int mode);
      color_type c;
      int span, gap;
      set_span(span_value);
      case (mode)
         0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
         2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
         default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      span = search_span();
      for (int i = 0; i < items; i++) begin
         gap = first_gap();
         if (gap >= 0) begin
            send_request(OP_LOAD, gap[INDEX_W-1:0], pick_color());
         end else if ($urandom_range(99) < 45) begin
            // mostly rewrite slots that are searched
            if ($urandom_range(9) < 7)
               send_request(OP_LOAD, INDEX_W'($urandom_range(span - 1)), pick_color());
            else
               send_request(OP_LOAD, INDEX_W'($urandom_range(255)), pick_color());
         end else begin
            if ($urandom_range(4) == 0)
               c = palette_copy[$urandom_range(span - 1)];
            else
               c = pick_color();
            send_request(OP_QUERY, INDEX_W'($urandom_range(255)), c);
         end
      end
      drain_pipeline();
      send_idle_pct = 0;
      recv_stall_pct = 0;
   endtask

   task automatic test_random_traffic();
      run_random_phase(1, 140, 0);
      run_random_phase(2, 140, 1);
      run_random_phase(17, 140, 2);
      run_random_phase(256, 60, 3);
      run_random_phase(64, 140, 0);
      run_random_phase($urandom_range(511, 257), 60, 1);
      run_random_phase(5, 140, 2);
      run_random_phase($urandom_range(32, 1), 140, 3);
   endtask

   initial begin : main
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_default();
      test_ties_and_extremes();
      test_palette_fill();
      test_span_limits();
      test_random_traffic();
      drain_pipeline();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (nearest_expected.size() != 0) begin
         mismatch_count += nearest_expected.size();
         $display("ERROR %0d queries never answered", nearest_expected.size());
      end
      $display("Ran %0d palette loads and %0d color queries across %0d register writes,",
               load_count, query_count, csr_write_count);
      $display("with search spans from 1 to 256 entries, ties, and random gaps and stalls.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
